### rtl/core/sqv_pkg.sv
package sqv_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;

	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_ITER_PER_STAGE = 4;
	localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_ITER_PER_STAGE;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] COS_ZERO = 32'sh4000_0000;

	localparam int DIV_BPS = 2;

	localparam int SAT_W = 72;

	localparam logic [1:0] MIRROR_MASK = 2'b11;
	localparam logic [1:0] CORNER_LAST = 2'd3;

	localparam int FLAG_TEXELS = 2;
	localparam int FLAG_PIXELS = 3;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TEX_WIDTH = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TEX_HEIGHT = 4'd3;

	localparam logic [14:0] TEX_SIZE_RST = 15'd1;
	localparam logic [31:0] INV_TEX_RST = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic [30:0] src_w;
		logic [30:0] src_h;
		logic signed [31:0] dst_x;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_w;
		logic signed [31:0] dst_h;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [15:0] angle;
		logic [3:0] flags;
	} spr_in_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sw;
		logic signed [31:0] sh;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dw;
		logic signed [31:0] dh;
		logic signed [31:0] sn;
		logic signed [31:0] cs;
		logic [1:0] mirror;
	} spr_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458908;
			3: r = 32'd85004756;
			4: r = 32'd42667330;
			5: r = 32'd21354465;
			6: r = 32'd10679837;
			7: r = 32'd5340247;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41721;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v[SAT_W-1:31] == '0 || v[SAT_W-1:31] == '1) begin
			r = v[31:0];
		end else if (v[SAT_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

### rtl/core/sqv_div.sv
module sqv_div
	import sqv_pkg::*;
#(
	parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input logic signed [31:0] num,
	input logic [30:0] den,
	output logic signed [31:0] quo
);

	localparam int DW = ((32 + FRAC_BITS + DIV_BPS - 1) / DIV_BPS) * DIV_BPS;
	localparam int NS = DW / DIV_BPS;
	localparam logic [DW-1:0] LIM_NEG = DW'(64'h8000_0000);
	localparam logic [DW-1:0] LIM_POS = DW'(64'h7FFF_FFFF);

	logic [31:0] rem_s [NS];
	logic [DW-1:0] num_s [NS];
	logic [DW-1:0] quo_s [NS];
	logic [30:0] den_s [NS];
	logic neg_s [NS];

	logic [31:0] mag;
	logic [DW-1:0] num_in;
	logic [30:0] den_in;
	logic [DW-1:0] qm;

	assign mag = num[31] ? 32'(-num) : 32'(num);
	assign num_in = DW'({mag, {FRAC_BITS{1'b0}}});
	assign den_in = (den == '0) ? 31'd1 : den;

	genvar g;
	for (g = 0; g < NS; g++) begin : g_stage
		logic [31:0] r_in;
		logic [DW-1:0] n_in;
		logic [DW-1:0] q_in;
		logic [30:0] d_in;
		logic s_in;
		logic [31:0] r_c;
		logic [DW-1:0] n_c;
		logic [DW-1:0] q_c;

		if (g == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num_in;
			assign q_in = '0;
			assign d_in = den_in;
			assign s_in = num[31];
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign n_in = num_s[g-1];
			assign q_in = quo_s[g-1];
			assign d_in = den_s[g-1];
			assign s_in = neg_s[g-1];
		end

		always_comb begin : p_step
			logic [31:0] r2;
			r_c = r_in;
			n_c = n_in;
			q_c = q_in;
			r2 = '0;
			for (int k = 0; k < DIV_BPS; k++) begin
				r2 = {r_c[30:0], n_c[DW-1]};
				n_c = n_c << 1;
				if (r2 >= {1'b0, d_in}) begin
					r_c = r2 - {1'b0, d_in};
					q_c = {q_c[DW-2:0], 1'b1};
				end else begin
					r_c = r2;
					q_c = {q_c[DW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_c;
				num_s[g] <= n_c;
				quo_s[g] <= q_c;
				den_s[g] <= d_in;
				neg_s[g] <= s_in;
			end
		end
	end

	assign qm = quo_s[NS-1];

	// truncate toward zero, saturate to 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[NS-1]) begin
				quo <= (qm > LIM_NEG) ? 32'sh8000_0000 : 32'(-qm);
			end else begin
				quo <= (qm > LIM_POS) ? 32'sh7FFF_FFFF : qm[31:0];
			end
		end
	end

endmodule

### rtl/core/sqv_cordic.sv
module sqv_cordic
	import sqv_pkg::*;
(
	input logic clk,
	input logic en,
	input logic [31:0] phase,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);

	logic signed [33:0] x_s [CORDIC_STAGES+1];
	logic signed [33:0] y_s [CORDIC_STAGES+1];
	logic signed [33:0] z_s [CORDIC_STAGES+1];
	logic flip_s [CORDIC_STAGES+1];
	logic zero_s [CORDIC_STAGES+1];

	logic flip_in;
	logic [31:0] ph_in;
	logic [31:0] ph_rot;

	assign ph_rot = phase + 32'h4000_0000;
	assign flip_in = ph_rot[31];
	assign ph_in = flip_in ? (phase + 32'h8000_0000) : phase;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= 34'($signed(ph_in));
			flip_s[0] <= flip_in;
			zero_s[0] <= (phase == '0);
		end
	end

	genvar g;
	for (g = 1; g <= CORDIC_STAGES; g++) begin : g_stage
		logic signed [33:0] x_c;
		logic signed [33:0] y_c;
		logic signed [33:0] z_c;

		always_comb begin : p_iter
			logic signed [33:0] xs;
			logic signed [33:0] ys;
			logic signed [33:0] at;
			x_c = x_s[g-1];
			y_c = y_s[g-1];
			z_c = z_s[g-1];
			xs = '0;
			ys = '0;
			at = '0;
			for (int k = 0; k < CORDIC_ITER_PER_STAGE; k++) begin
				xs = x_c >>> ((g - 1) * CORDIC_ITER_PER_STAGE + k);
				ys = y_c >>> ((g - 1) * CORDIC_ITER_PER_STAGE + k);
				at = $signed({2'b00, atan_turn((g - 1) * CORDIC_ITER_PER_STAGE + k)});
				if (!z_c[33]) begin
					x_c = x_c - ys;
					y_c = y_c + xs;
					z_c = z_c - at;
				end else begin
					x_c = x_c + ys;
					y_c = y_c - xs;
					z_c = z_c + at;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g] <= x_c;
				y_s[g] <= y_c;
				z_s[g] <= z_c;
				flip_s[g] <= flip_s[g-1];
				zero_s[g] <= zero_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[CORDIC_STAGES]) begin
				sn <= '0;
				cs <= COS_ZERO;
			end else if (flip_s[CORDIC_STAGES]) begin
				sn <= 32'(-y_s[CORDIC_STAGES]);
				cs <= 32'(-x_s[CORDIC_STAGES]);
			end else begin
				sn <= y_s[CORDIC_STAGES][31:0];
				cs <= x_s[CORDIC_STAGES][31:0];
			end
		end
	end

endmodule

### rtl/core/sqv_corner.sv
module sqv_corner
	import sqv_pkg::*;
#(
	parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic spr_valid,
	input spr_t spr,
	output logic spr_take,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] corner,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic last
);

	localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

	logic en_c;
	spr_t spr_q;
	logic spr_v_q;
	logic [1:0] cnt_q;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;

	logic signed [32:0] ddx;
	logic signed [32:0] ddy;
	logic signed [64:0] pox;
	logic signed [64:0] poy;
	logic [1:0] tsel;

	logic signed [31:0] offx_s1, offy_s1, u_s1, v_s1, dx_s1, dy_s1, sn_s1, cs_s1;
	logic [1:0] crn_s1;
	logic last_s1;

	logic signed [63:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [31:0] u_s2, v_s2, dx_s2, dy_s2;
	logic [1:0] crn_s2;
	logic last_s2;

	logic signed [64:0] dfx;
	logic signed [64:0] dfy;

	assign en_c = !vld_s3 || out_ready;
	assign spr_take = !spr_v_q || (en_c && cnt_q == CORNER_LAST);
	assign out_valid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_v_q <= 1'b0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (spr_take) begin
				spr_v_q <= spr_valid;
				cnt_q <= '0;
			end else if (en_c) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (en_c) begin
				vld_s1 <= spr_v_q;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (spr_take) begin
			spr_q <= spr;
		end
	end

	// corner offset from origin, scaled by size
	assign ddx = (cnt_q[0] ? ONE : 33'sd0) - 33'($signed(spr_q.ox));
	assign ddy = (cnt_q[1] ? ONE : 33'sd0) - 33'($signed(spr_q.oy));
	assign pox = ddx * $signed(spr_q.dw);
	assign poy = ddy * $signed(spr_q.dh);
	assign tsel = cnt_q ^ (spr_q.mirror & MIRROR_MASK);

	always_ff @(posedge clk) begin
		if (en_c) begin
			offx_s1 <= sat32(SAT_W'(pox >>> FRAC_BITS));
			offy_s1 <= sat32(SAT_W'(poy >>> FRAC_BITS));
			u_s1 <= sat32(SAT_W'($signed(spr_q.sx))
				+ (tsel[0] ? SAT_W'($signed(spr_q.sw)) : SAT_W'(0)));
			v_s1 <= sat32(SAT_W'($signed(spr_q.sy))
				+ (tsel[1] ? SAT_W'($signed(spr_q.sh)) : SAT_W'(0)));
			dx_s1 <= spr_q.dx;
			dy_s1 <= spr_q.dy;
			sn_s1 <= spr_q.sn;
			cs_s1 <= spr_q.cs;
			crn_s1 <= cnt_q;
			last_s1 <= (cnt_q == CORNER_LAST);
		end
	end

	// rotation products
	always_ff @(posedge clk) begin
		if (en_c) begin
			p0_s2 <= offx_s1 * cs_s1;
			p1_s2 <= offy_s1 * sn_s1;
			p2_s2 <= offx_s1 * sn_s1;
			p3_s2 <= offy_s1 * cs_s1;
			u_s2 <= u_s1;
			v_s2 <= v_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			crn_s2 <= crn_s1;
			last_s2 <= last_s1;
		end
	end

	assign dfx = 65'(p0_s2) - 65'(p1_s2);
	assign dfy = 65'(p2_s2) + 65'(p3_s2);

	always_ff @(posedge clk) begin
		if (en_c) begin
			pos_x <= sat32(SAT_W'(dx_s2) + SAT_W'(dfx >>> 30));
			pos_y <= sat32(SAT_W'(dy_s2) + SAT_W'(dfy >>> 30));
			tex_u <= u_s2;
			tex_v <= v_s2;
			corner <= crn_s2;
			last <= last_s2;
		end
	end

endmodule

### rtl/core/sprite_quad_vertex_generator_core.sv
// throughput: one corner word per cycle on the output while out_ready is high and sprites
// keep arriving; each sprite yields four corner words, and new sprites enter the pipeline
// while earlier ones are still being processed
// reset: clears all valid bits and loads the texture registers with size 1 and
// reciprocal 1.0; pipeline data registers are not reset
module sprite_quad_vertex_generator_core
	import sqv_pkg::*;
#(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] src_x,
	input logic signed [31:0] src_y,
	input logic [30:0] src_w,
	input logic [30:0] src_h,
	input logic signed [31:0] dst_x,
	input logic signed [31:0] dst_y,
	input logic signed [31:0] dst_w,
	input logic signed [31:0] dst_h,
	input logic signed [31:0] origin_x,
	input logic signed [31:0] origin_y,
	input logic [15:0] angle,
	input logic [3:0] flags,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] corner,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int DIV_W = ((32 + COORD_FRAC_BITS + DIV_BPS - 1) / DIV_BPS) * DIV_BPS;
	localparam int DIV_STAGES = DIV_W / DIV_BPS;
	localparam int DIV_LAT = DIV_STAGES + 1;
	localparam int SC_DLY = DIV_LAT - CORDIC_LAT;

	logic [14:0] tex_w_q;
	logic [14:0] tex_h_q;
	logic [31:0] inv_w_q;
	logic [31:0] inv_h_q;

	logic en_sp;
	logic spr_take;

	spr_in_t in_word;
	spr_in_t in_s1;
	logic v_s1;
	logic [31:0] phase;

	logic signed [31:0] quo_x;
	logic signed [31:0] quo_y;
	logic signed [31:0] sn_c;
	logic signed [31:0] cs_c;

	spr_in_t fld_s [DIV_LAT];
	logic [DIV_LAT-1:0] vld_s;
	logic signed [31:0] sn_s [SC_DLY];
	logic signed [31:0] cs_s [SC_DLY];

	spr_in_t ft;
	logic texel;
	logic signed [31:0] mx;
	logic signed [31:0] my;
	logic signed [64:0] pmx;
	logic signed [64:0] pmy;
	logic signed [64:0] psw;
	logic signed [64:0] psh;
	logic signed [47:0] pdw;
	logic signed [47:0] pdh;
	logic signed [31:0] nx;
	logic signed [31:0] ny;

	spr_t nrm_s;
	logic nrm_v_s;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= TEX_SIZE_RST;
			tex_h_q <= TEX_SIZE_RST;
			inv_w_q <= INV_TEX_RST;
			inv_h_q <= INV_TEX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEX_WIDTH: tex_w_q <= cfg_data[14:0];
				REG_TEX_HEIGHT: tex_h_q <= cfg_data[14:0];
				REG_INV_TEX_WIDTH: inv_w_q <= cfg_data;
				REG_INV_TEX_HEIGHT: inv_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sprite pipeline moves as one
	assign en_sp = !nrm_v_s || spr_take;
	assign in_ready = en_sp;

	always_comb begin
		in_word.src_x = src_x;
		in_word.src_y = src_y;
		in_word.src_w = src_w;
		in_word.src_h = src_h;
		in_word.dst_x = dst_x;
		in_word.dst_y = dst_y;
		in_word.dst_w = dst_w;
		in_word.dst_h = dst_h;
		in_word.origin_x = origin_x;
		in_word.origin_y = origin_y;
		in_word.angle = angle;
		in_word.flags = flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vld_s <= '0;
			nrm_v_s <= 1'b0;
		end else if (en_sp) begin
			v_s1 <= in_valid;
			vld_s <= {vld_s[DIV_LAT-2:0], v_s1};
			nrm_v_s <= vld_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sp && in_valid) begin
			in_s1 <= in_word;
		end
	end

	assign phase = {in_s1.angle, 16'h0000} & ~(32'hFFFF_FFFF >> ANGLE_BITS);

	sqv_div #(
		.FRAC_BITS(COORD_FRAC_BITS)
	) u_div_x (
		.clk(clk),
		.en(en_sp),
		.num(in_s1.origin_x),
		.den(in_s1.src_w),
		.quo(quo_x)
	);

	sqv_div #(
		.FRAC_BITS(COORD_FRAC_BITS)
	) u_div_y (
		.clk(clk),
		.en(en_sp),
		.num(in_s1.origin_y),
		.den(in_s1.src_h),
		.quo(quo_y)
	);

	sqv_cordic u_cordic (
		.clk(clk),
		.en(en_sp),
		.phase(phase),
		.sn(sn_c),
		.cs(cs_c)
	);

	// fields and sin/cos wait for the divider
	always_ff @(posedge clk) begin
		if (en_sp) begin
			fld_s[0] <= in_s1;
			for (int k = 1; k < DIV_LAT; k++) begin
				fld_s[k] <= fld_s[k-1];
			end
			sn_s[0] <= sn_c;
			cs_s[0] <= cs_c;
			for (int k = 1; k < SC_DLY; k++) begin
				sn_s[k] <= sn_s[k-1];
				cs_s[k] <= cs_s[k-1];
			end
		end
	end

	// texture normalization and size scaling
	assign ft = fld_s[DIV_LAT-1];
	assign texel = ft.flags[FLAG_TEXELS];
	assign mx = texel ? $signed(ft.src_x) : quo_x;
	assign my = texel ? $signed(ft.src_y) : quo_y;
	assign pmx = mx * $signed({1'b0, inv_w_q});
	assign pmy = my * $signed({1'b0, inv_h_q});
	assign psw = $signed({1'b0, ft.src_w}) * $signed({1'b0, inv_w_q});
	assign psh = $signed({1'b0, ft.src_h}) * $signed({1'b0, inv_h_q});
	assign pdw = $signed(ft.dst_w) * $signed({1'b0, tex_w_q});
	assign pdh = $signed(ft.dst_h) * $signed({1'b0, tex_h_q});
	assign nx = sat32(SAT_W'(pmx >>> 31));
	assign ny = sat32(SAT_W'(pmy >>> 31));

	always_ff @(posedge clk) begin
		if (en_sp) begin
			nrm_s.ox <= texel ? quo_x : nx;
			nrm_s.oy <= texel ? quo_y : ny;
			nrm_s.sx <= texel ? nx : $signed(ft.src_x);
			nrm_s.sy <= texel ? ny : $signed(ft.src_y);
			nrm_s.sw <= texel ? sat32(SAT_W'(psw >>> 31)) : $signed({1'b0, ft.src_w});
			nrm_s.sh <= texel ? sat32(SAT_W'(psh >>> 31)) : $signed({1'b0, ft.src_h});
			nrm_s.dx <= ft.dst_x;
			nrm_s.dy <= ft.dst_y;
			nrm_s.dw <= ft.flags[FLAG_PIXELS] ? $signed(ft.dst_w) : sat32(SAT_W'(pdw));
			nrm_s.dh <= ft.flags[FLAG_PIXELS] ? $signed(ft.dst_h) : sat32(SAT_W'(pdh));
			nrm_s.sn <= sn_s[SC_DLY-1];
			nrm_s.cs <= cs_s[SC_DLY-1];
			nrm_s.mirror <= ft.flags[1:0];
		end
	end

	sqv_corner #(
		.FRAC_BITS(COORD_FRAC_BITS)
	) u_corner (
		.clk(clk),
		.arst_n(arst_n),
		.spr_valid(nrm_v_s),
		.spr(nrm_s),
		.spr_take(spr_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.corner(corner),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.tex_u(tex_u),
		.tex_v(tex_v),
		.last(last)
	);

endmodule

### rtl/core/sqv_check.sv
module sqv_check
	import sqv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] corner,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] tex_u,
	input logic signed [31:0] tex_v,
	input logic last
);

	logic [1:0] exp_q;
	logic [7:0] pend_q;
	logic in_acc;
	logic out_acc;
	logic done;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign done = out_acc && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			pend_q <= '0;
		end else begin
			if (out_acc) begin
				exp_q <= exp_q + 2'd1;
			end
			if (in_acc && !done) begin
				pend_q <= pend_q + 8'd1;
			end else if (!in_acc && done) begin
				pend_q <= pend_q - 8'd1;
			end
		end
	end

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(corner) && $stable(pos_x)
			&& $stable(pos_y) && $stable(tex_u) && $stable(tex_v) && $stable(last))
		else $error("stalled output word changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (corner == CORNER_LAST)))
		else $error("last flag not on final corner");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (corner == exp_q))
		else $error("corner out of order");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pend_q != '0 || in_acc))
		else $error("quad finished without an accepted sprite");

endmodule

bind sprite_quad_vertex_generator_core sqv_check u_check (.*);

### tb/sprite_quad_vertex_generator_core_test.sv
`timescale 1ns / 100ps

module sprite_quad_vertex_generator_core_test;
	import sqv_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] corner;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic last;
	} vertex_t;

	class quad_scoreboard;
		vertex_t pending[$];
		logic [14:0] tw, th;
		logic [31:0] itw, ith;

		function new();
			tw = 15'd1;
			th = 15'd1;
			itw = 32'h8000_0000;
			ith = 32'h8000_0000;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_TEX_WIDTH: tw = data[14:0];
				REG_TEX_HEIGHT: th = data[14:0];
				REG_INV_TEX_WIDTH: itw = data;
				REG_INV_TEX_HEIGHT: ith = data;
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint recip_scale(longint v, logic [31:0] inv);
			longint p;
			p = v * longint'({32'd0, inv});
			return clamp(p >>> 31);
		endfunction

		function void rotor(logic [31:0] ph, output longint sn, output longint cs);
			longint x, y, z, xs, ys;
			longint atn;
			logic [31:0] p, t;
			bit flip;
			p = ph;
			t = p + 32'h4000_0000;
			flip = t[31];
			if (flip) p = p + 32'h8000_0000;
			x = 64'sd652032874;
			y = 64'sd0;
			z = longint'(signed'(p));
			for (int i = 0; i < 20; i++) begin
				atn = longint'({32'd0, atan_turn(i)});
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys; y = y + xs; z = z - atn;
				end else begin
					x = x + ys; y = y - xs; z = z + atn;
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			sn = y;
			cs = x;
		endfunction

		function void note(spr_in_t s);
			longint one, sx, sy, sw, sh, dx, dy, dw, dh, ox, oy, sn, cs;
			longint cx, cy, offx, offy;
			logic [1:0] t;
			vertex_t v;
			one = 64'sd65536;
			sx = longint'(s.src_x); sy = longint'(s.src_y);
			sw = longint'({33'd0, s.src_w}); sh = longint'({33'd0, s.src_h});
			dx = longint'(s.dst_x); dy = longint'(s.dst_y);
			dw = longint'(s.dst_w); dh = longint'(s.dst_h);
			ox = clamp((longint'(s.origin_x) * one) / (sw != 0 ? sw : 64'sd1));
			oy = clamp((longint'(s.origin_y) * one) / (sh != 0 ? sh : 64'sd1));
			if (s.flags[FLAG_TEXELS]) begin
				sx = recip_scale(sx, itw);
				sy = recip_scale(sy, ith);
				sw = recip_scale(sw, itw);
				sh = recip_scale(sh, ith);
			end else begin
				ox = recip_scale(ox, itw);
				oy = recip_scale(oy, ith);
			end
			if (!s.flags[FLAG_PIXELS]) begin
				dw = clamp(dw * longint'({49'd0, tw}));
				dh = clamp(dh * longint'({49'd0, th}));
			end
			if (s.angle != 0) begin
				rotor({s.angle, 16'h0}, sn, cs);
			end else begin
				sn = 64'sd0;
				cs = 64'sd1 << 30;
			end
			for (int i = 0; i < 4; i++) begin
				cx = i[0] ? one : 64'sd0;
				cy = i[1] ? one : 64'sd0;
				t = i[1:0] ^ s.flags[1:0];
				offx = clamp(((cx - ox) * dw) >>> 16);
				offy = clamp(((cy - oy) * dh) >>> 16);
				v.corner = i[1:0];
				v.pos_x = 32'(clamp(dx + ((offx * cs - offy * sn) >>> 30)));
				v.pos_y = 32'(clamp(dy + ((offx * sn + offy * cs) >>> 30)));
				v.tex_u = 32'(clamp(sx + (t[0] ? sw : 64'sd0)));
				v.tex_v = 32'(clamp(sy + (t[1] ? sh : 64'sd0)));
				v.last = (i == 3);
				pending.push_back(v);
			end
		endfunction

		function string check(vertex_t got);
			vertex_t e;
			if (pending.size() == 0) return $sformatf("unexpected word %p", got);
			e = pending.pop_front();
			if (got !== e) return $sformatf("got %p want %p", got, e);
			return "";
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	spr_in_t item = '0;
	logic out_valid;
	logic out_ready = 0;
	vertex_t word;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	quad_scoreboard sb = new();
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	always #6 clk = ~clk;

	sprite_quad_vertex_generator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.src_x(item.src_x), .src_y(item.src_y), .src_w(item.src_w), .src_h(item.src_h),
		.dst_x(item.dst_x), .dst_y(item.dst_y), .dst_w(item.dst_w), .dst_h(item.dst_h),
		.origin_x(item.origin_x), .origin_y(item.origin_y),
		.angle(item.angle), .flags(item.flags),
		.out_valid(out_valid), .out_ready(out_ready),
		.corner(word.corner), .pos_x(word.pos_x), .pos_y(word.pos_y),
		.tex_u(word.tex_u), .tex_v(word.tex_v), .last(word.last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	task automatic report(string msg);
		$display("error: %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sprite_quad_vertex_generator_core: mismatch");
			$finish;
		end
		if (out_valid && out_ready) begin
			msg = sb.check(word);
			if (msg != "") report(msg);
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready = 0;
			hold_off--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] pick32();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'($urandom_range(32'h40000)) - 32'h20000;
			4: return 32'($urandom_range(32'h1000000)) - 32'h800000;
			default: return $urandom;
		endcase
	endfunction

	function automatic spr_in_t rand_item();
		spr_in_t s;
		s.src_x = pick32(); s.src_y = pick32();
		s.src_w = 31'(pick32()); s.src_h = 31'(pick32());
		s.dst_x = pick32(); s.dst_y = pick32();
		s.dst_w = pick32(); s.dst_h = pick32();
		s.origin_x = pick32(); s.origin_y = pick32();
		case ($urandom_range(3))
			0: s.angle = 16'h0;
			1: s.angle = 16'($urandom_range(3)) << 14;
			default: s.angle = 16'($urandom);
		endcase
		s.flags = 4'($urandom);
		return s;
	endfunction

	task automatic send_item(spr_in_t s);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		item = s;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note(s);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_regs(logic [31:0] w, logic [31:0] h, logic [31:0] iw, logic [31:0] ih);
		drain();
		write_reg(REG_TEX_WIDTH, w);
		write_reg(REG_TEX_HEIGHT, h);
		write_reg(REG_INV_TEX_WIDTH, iw);
		write_reg(REG_INV_TEX_HEIGHT, ih);
	endtask

	task automatic directed();
		spr_in_t s;
		for (int i = 0; i < 20; i++) begin
			s = '0;
			s.src_w = 31'h10000; s.src_h = 31'h10000;
			s.dst_w = 32'h10000; s.dst_h = 32'h10000;
			s.flags = 4'(i);
			case (i)
				0: ;
				1: s = '1;
				2: begin
					s.src_x = 32'h7FFF_FFFF; s.src_y = 32'h8000_0000;
					s.src_w = '1; s.src_h = '1;
				end
				3: begin
					s.dst_x = 32'h7FFF_FFFF; s.dst_y = 32'h8000_0000;
					s.dst_w = 32'h7FFF_FFFF; s.dst_h = 32'h8000_0000;
				end
				4: begin
					s.src_w = 0; s.src_h = 0;
					s.origin_x = 32'h7FFF_FFFF; s.origin_y = 32'h8000_0000;
				end
				5: begin
					s.src_w = 0; s.origin_x = 32'h8000; s.origin_y = 32'h8000;
				end
				6: s.angle = 16'h4000;
				7: s.angle = 16'h8000;
				8: s.angle = 16'hC000;
				9: s.angle = 16'hFFFF;
				10: s.angle = 16'h0001;
				11: begin
					s.angle = 16'h2000; s.origin_x = 32'h8000; s.origin_y = 32'h8000;
				end
				default: s = rand_item();
			endcase
			send_item(s);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		directed();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ;
				1: load_regs(32'd16384, 32'd16384, 32'h0002_0000, 32'h0002_0000);
				2: load_regs(32'd0, 32'd0, 32'd0, 32'd0);
				3: load_regs(32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF, 32'h1249_2492);
				4: begin
					load_regs($urandom, $urandom, $urandom, $urandom);
					write_reg(REG_UNUSED, $urandom);
				end
				default: load_regs(32'd1, 32'd1, 32'h8000_0000, 32'h8000_0000);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			if (ph == 1) hold_off = 300;
			for (int n = 0; n < 50; n++) send_item(rand_item());
		end
		drain();
		if (errors == 0) begin
			$display("sprite_quad_vertex_generator_core: match");
		end else begin
			$display("sprite_quad_vertex_generator_core: mismatch");
		end
		$finish;
	end

endmodule
